@@ sv/multi_port_mouse_delta_accumulator_defines.svh @@
// Assertion macros for the mouse delta accumulator.
// Used by modules that take clk and arst_n; no other dependencies.
`ifndef MULTI_PORT_MOUSE_DELTA_ACCUMULATOR_DEFINES_SVH
`define MULTI_PORT_MOUSE_DELTA_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define MPMDA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpmda assertion failed");

// Next-cycle implication, checked on clk, off during reset.
`define MPMDA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpmda assertion failed");

`endif

@@ sv/mpmda_pkg.sv @@
// Shared types, codes and helper functions for the mouse delta accumulator.
// No dependencies.
package mpmda_pkg;

	localparam int NUM_PORTS_DEF = 8;
	localparam int PIU_W         = 4;

	localparam logic [2:0] CMD_MOVE   = 3'd0;
	localparam logic [2:0] CMD_BUTTON = 3'd1;
	localparam logic [2:0] CMD_WHEEL  = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_LIST   = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNINIT    = 3'd1;
	localparam logic [2:0] ST_BAD_PORT  = 3'd2;
	localparam logic [2:0] ST_NO_DEVICE = 3'd3;
	localparam logic [2:0] ST_IGNORED   = 3'd4;

	localparam logic REG_PORTS_IN_USE = 1'b0;

	typedef struct packed {
		logic [PIU_W-1:0] ports_in_use;
		logic             clear_all;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        command;
		logic [7:0]        port;
		logic signed [7:0] delta_x;
		logic signed [7:0] delta_y;
		logic signed [7:0] wheel_step;
		logic [7:0]        button_bits;
		logic              pressed;
	} item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic              entry_count;
		logic              update_flag;
		logic [7:0]        button_state;
		logic signed [7:0] x_motion;
		logic signed [7:0] y_motion;
		logic signed [7:0] wheel_motion;
	} result_t;

	// Add a signed byte into a 16-bit accumulator, saturating at both ends.
	function automatic logic signed [15:0] sat_add16(logic signed [15:0] acc,
			logic signed [7:0] d);
		logic signed [16:0] s;
		s = {acc[15], acc} + {{9{d[7]}}, d};
		if (s[16] != s[15]) begin
			sat_add16 = s[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			sat_add16 = s[15:0];
		end
	endfunction

	// Clamp a 16-bit accumulator to one signed byte.
	function automatic logic signed [7:0] clamp8(logic signed [15:0] v);
		if (v > 16'sd127) begin
			clamp8 = 8'sd127;
		end else if (v < -16'sd128) begin
			clamp8 = -8'sd128;
		end else begin
			clamp8 = v[7:0];
		end
	endfunction

endpackage

@@ sv/mpmda_apb.sv @@
// APB-style configuration register: holds ports_in_use, flags a full clear.
// Depends on mpmda_pkg.
module mpmda_apb (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output mpmda_pkg::cfg_t     cfg
);
	import mpmda_pkg::*;

	logic [PIU_W-1:0] piu_q;
	logic             wr_hit;
	logic [PIU_W-1:0] wr_val;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_PORTS_IN_USE);
	assign wr_val = pwdata[PIU_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piu_q <= '0;
		end else if (wr_hit) begin
			piu_q <= wr_val;
		end
	end

	// Raising the port count wipes all port state in the same edge.
	assign cfg.ports_in_use = piu_q;
	assign cfg.clear_all    = wr_hit && (wr_val > piu_q);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PORTS_IN_USE) begin
			prdata[PIU_W-1:0] = piu_q;
		end
	end

endmodule

@@ sv/mpmda_port_state.sv @@
// Per-port register file and the single-pass event/read logic.
// Depends on mpmda_pkg and multi_port_mouse_delta_accumulator_defines.svh.
module mpmda_port_state #(
	parameter int NUM_PORTS = mpmda_pkg::NUM_PORTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mpmda_pkg::cfg_t     cfg,
	input  mpmda_pkg::item_t    item_s1,
	input  logic                advance,
	output mpmda_pkg::result_t  res
);
	import mpmda_pkg::*;
	`include "multi_port_mouse_delta_accumulator_defines.svh"

	localparam int         IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam logic [7:0] NP8   = 8'(NUM_PORTS);

	logic [NUM_PORTS-1:0]  conn_q;
	logic [NUM_PORTS-1:0]  upd_q;
	logic [7:0]            btn_q  [NUM_PORTS];
	logic signed [15:0]    sx_q   [NUM_PORTS];
	logic signed [15:0]    sy_q   [NUM_PORTS];
	logic signed [15:0]    sw_q   [NUM_PORTS];

	logic [7:0]         piu8;
	logic [7:0]         limit;
	logic               init;
	logic               in_range;
	logic               in_limit;
	logic [IDX_W-1:0]   idx;
	logic               is_event;
	logic               is_query;
	logic               ev_ok;
	logic               snap;
	logic               drop;
	logic [7:0]         btn_nxt;
	logic signed [15:0] sx_nxt;
	logic signed [15:0] sy_nxt;
	logic signed [15:0] sw_nxt;

	assign piu8     = {{(8-PIU_W){1'b0}}, cfg.ports_in_use};
	assign limit    = (piu8 > NP8) ? NP8 : piu8;
	assign init     = (cfg.ports_in_use != '0);
	assign in_range = (item_s1.port < NP8);
	assign in_limit = (item_s1.port < limit);
	assign idx      = in_range ? item_s1.port[IDX_W-1:0] : '0;

	assign is_event = (item_s1.command == CMD_MOVE) || (item_s1.command == CMD_BUTTON) ||
	                  (item_s1.command == CMD_WHEEL);
	assign is_query = (item_s1.command == CMD_READ) || (item_s1.command == CMD_LIST);
	assign ev_ok    = is_event && init && in_range;

	always_comb begin
		res  = '0;
		snap = 1'b0;
		drop = 1'b0;
		if (is_event) begin
			res.status = ev_ok ? ST_OK : ST_IGNORED;
		end else if (is_query) begin
			if (!init) begin
				res.status = ST_UNINIT;
			end else if (!in_limit) begin
				res.status = ST_BAD_PORT;
			end else if (!conn_q[idx]) begin
				res.status = ST_NO_DEVICE;
			end else begin
				res.status = ST_OK;
				snap = (item_s1.command == CMD_READ) || upd_q[idx];
				res.entry_count = (item_s1.command == CMD_LIST) && upd_q[idx];
			end
		end else if (item_s1.command == CMD_CLEAR) begin
			if (!init) begin
				res.status = ST_UNINIT;
			end else if (!in_range) begin
				res.status = ST_BAD_PORT;
			end else begin
				res.status = ST_OK;
				drop = 1'b1;
			end
		end else begin
			res.status = ST_IGNORED;
		end
		if (snap) begin
			res.update_flag  = upd_q[idx];
			res.button_state = btn_q[idx];
			res.x_motion     = clamp8(sx_q[idx]);
			res.y_motion     = clamp8(sy_q[idx]);
			res.wheel_motion = clamp8(sw_q[idx]);
			drop = 1'b1;
		end
	end

	always_comb begin
		btn_nxt = btn_q[idx];
		sx_nxt  = sx_q[idx];
		sy_nxt  = sy_q[idx];
		sw_nxt  = sw_q[idx];
		case (item_s1.command)
			CMD_MOVE: begin
				sx_nxt = sat_add16(sx_q[idx], item_s1.delta_x);
				sy_nxt = sat_add16(sy_q[idx], item_s1.delta_y);
			end
			CMD_BUTTON: begin
				btn_nxt = item_s1.pressed ? (btn_q[idx] | item_s1.button_bits)
				                          : (btn_q[idx] & ~item_s1.button_bits);
			end
			CMD_WHEEL: begin
				sw_nxt = sat_add16(sw_q[idx], item_s1.wheel_step);
			end
			default: begin
				btn_nxt = btn_q[idx];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_q <= NUM_PORTS'(1);
			upd_q  <= '0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				btn_q[i] <= '0;
				sx_q[i]  <= '0;
				sy_q[i]  <= '0;
				sw_q[i]  <= '0;
			end
		end else if (cfg.clear_all) begin
			conn_q <= NUM_PORTS'(1);
			upd_q  <= '0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				btn_q[i] <= '0;
				sx_q[i]  <= '0;
				sy_q[i]  <= '0;
				sw_q[i]  <= '0;
			end
		end else if (advance) begin
			if (ev_ok) begin
				conn_q[idx] <= 1'b1;
				upd_q[idx]  <= 1'b1;
				btn_q[idx]  <= btn_nxt;
				sx_q[idx]   <= sx_nxt;
				sy_q[idx]   <= sy_nxt;
				sw_q[idx]   <= sw_nxt;
			end else if (drop) begin
				upd_q[idx] <= 1'b0;
				sx_q[idx]  <= '0;
				sy_q[idx]  <= '0;
				sw_q[idx]  <= '0;
			end
		end
	end

	`MPMDA_ASSERT_NEXT(a_clear_all_resets_ports, cfg.clear_all, conn_q == NUM_PORTS'(1) && upd_q == '0)
	`MPMDA_ASSERT_NEXT(a_event_marks_port, advance && ev_ok && !cfg.clear_all, conn_q[$past(idx)] && upd_q[$past(idx)])
	`MPMDA_ASSERT_NEXT(a_snapshot_drops_update, advance && snap && !cfg.clear_all, !upd_q[$past(idx)])
	`MPMDA_ASSERT_NEXT(a_uninit_no_change, advance && !init && !cfg.clear_all, $stable(conn_q) && $stable(upd_q))
	`MPMDA_ASSERT_NOW(a_list_count_needs_ok, res.entry_count, res.status == ST_OK && res.update_flag)

endmodule

@@ sv/multi_port_mouse_delta_accumulator.sv @@
// Top level of the multi-port mouse delta accumulator: input stage, result stage.
// Depends on mpmda_pkg, mpmda_apb and mpmda_port_state.
//
// Keeps button mask, saturating 16-bit x/y/wheel sums, a connected flag and an
// updated flag for each of NUM_PORTS mouse ports. Each input beat carries one
// command (move, button, wheel, read, list read, clear) and yields exactly one
// result beat. Throughput is one beat per clock while result_ready stays high:
// a beat is captured in the input register, and when it advances the
// addressed port's registers are read, modified and written back while the
// result is loaded into the output register, so a beat on the same port right
// behind sees the new state. result_valid is that register's valid flag. While
// a result waits for result_ready the input register still takes one more beat;
// after that item_ready stays low until the waiting result is taken.
// ports_in_use (APB offset 0x0) must be nonzero before events are taken;
// writing a larger value than the current one wipes every port and marks
// port 0 connected. Write it only while no beat is in flight.
// There is no clearing pass after reset.
module multi_port_mouse_delta_accumulator #(
	parameter int NUM_PORTS = mpmda_pkg::NUM_PORTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	// Command channel
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [2:0]        command,
	input  logic [7:0]        port,
	input  logic signed [7:0] delta_x,
	input  logic signed [7:0] delta_y,
	input  logic signed [7:0] wheel_step,
	input  logic [7:0]        button_bits,
	input  logic              pressed,

	// Result channel
	output logic              result_valid,
	input  logic              result_ready,
	output logic [2:0]        status,
	output logic              entry_count,
	output logic              update_flag,
	output logic [7:0]        button_state,
	output logic signed [7:0] x_motion,
	output logic signed [7:0] y_motion,
	output logic signed [7:0] wheel_motion
);
	import mpmda_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    vld_s1;
	result_t res;
	result_t res_s2;
	logic    vld_s2;
	logic    advance;

	mpmda_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the input stage when the result register is free or draining.
	assign advance    = vld_s1 && (!vld_s2 || result_ready);
	assign item_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_ready) begin
			vld_s1 <= item_valid;
		end
	end

	// Capture the payload of each accepted beat; hold it otherwise.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1.command     <= command;
			item_s1.port        <= port;
			item_s1.delta_x     <= delta_x;
			item_s1.delta_y     <= delta_y;
			item_s1.wheel_step  <= wheel_step;
			item_s1.button_bits <= button_bits;
			item_s1.pressed     <= pressed;
		end
	end

	mpmda_port_state #(
		.NUM_PORTS (NUM_PORTS)
	) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item_s1 (item_s1),
		.advance (advance),
		.res     (res)
	);

	// Result register: load on advance, drop valid once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (result_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result_valid = vld_s2;
	assign status       = res_s2.status;
	assign entry_count  = res_s2.entry_count;
	assign update_flag  = res_s2.update_flag;
	assign button_state = res_s2.button_state;
	assign x_motion     = res_s2.x_motion;
	assign y_motion     = res_s2.y_motion;
	assign wheel_motion = res_s2.wheel_motion;

endmodule

@@ tb/sv/multi_port_mouse_delta_accumulator_tb.sv @@
// Self-checking testbench for multi_port_mouse_delta_accumulator.
// Depends on mpmda_pkg and the block's RTL; drives command beats and APB writes,
// predicts every result beat in a scoreboard class and compares field by field.
module multi_port_mouse_delta_accumulator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mpmda_pkg::*;

	localparam int N_PORTS        = NUM_PORTS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int MAX_SEND_GAP   = 30;
	localparam int MAX_REPORTS    = 10;

	// Codes outside the defined command set; the block must ignore them.
	localparam logic [2:0] CMD_RSVD_A = 3'd6;
	localparam logic [2:0] CMD_RSVD_B = 3'd7;

	// APB byte address of ports_in_use: register index times four.
	localparam logic [2:0] PIU_ADDR = {REG_PORTS_IN_USE, 2'b00};

	// Long runs of one delta kind, used to push a port's sum into saturation.
	localparam int BURST_NONE  = 0;
	localparam int BURST_MOVE  = 1;
	localparam int BURST_WHEEL = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic              item_valid = 1'b0;
	logic              item_ready;
	logic [2:0]        command = '0;
	logic [7:0]        port = '0;
	logic signed [7:0] delta_x = '0;
	logic signed [7:0] delta_y = '0;
	logic signed [7:0] wheel_step = '0;
	logic [7:0]        button_bits = '0;
	logic              pressed = 1'b0;

	logic              result_valid;
	logic              result_ready = 1'b0;
	logic [2:0]        status;
	logic              entry_count;
	logic              update_flag;
	logic [7:0]        button_state;
	logic signed [7:0] x_motion;
	logic signed [7:0] y_motion;
	logic signed [7:0] wheel_motion;

	// Idle and stall percentages of the current phase, read by the drivers; quiet count for the watchdog.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	multi_port_mouse_delta_accumulator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.port         (port),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.wheel_step   (wheel_step),
		.button_bits  (button_bits),
		.pressed      (pressed),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.entry_count  (entry_count),
		.update_flag  (update_flag),
		.button_state (button_state),
		.x_motion     (x_motion),
		.y_motion     (y_motion),
		.wheel_motion (wheel_motion)
	);

	// Mouse port model plus the queue of result beats still owed by the block.
	class mouse_scoreboard;
		logic [3:0] ports_in_use;
		bit         connected [N_PORTS];
		logic [7:0] buttons [N_PORTS];
		int         acc_x [N_PORTS];
		int         acc_y [N_PORTS];
		int         wheel_acc [N_PORTS];
		bit         touched [N_PORTS];
		result_t    owed_q [$];
		int         failures;

		function new();
			failures = 0;
			ports_in_use = '0;
			wipe_ports();
		endfunction

		function void wipe_ports();
			for (int i = 0; i < N_PORTS; i++) begin
				connected[i] = 1'b0;
				buttons[i] = '0;
				acc_x[i] = 0;
				acc_y[i] = 0;
				wheel_acc[i] = 0;
				touched[i] = 1'b0;
			end
			connected[0] = 1'b1;
		endfunction

		// Raising the port count wipes every port; lowering it keeps state.
		function void write_ports_in_use(logic [3:0] v);
			if (v > ports_in_use) wipe_ports();
			ports_in_use = v;
		endfunction

		function int saturate16(int v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return v;
		endfunction

		function logic signed [7:0] clip8(int v);
			if (v > 127) return 8'h7f;
			if (v < -128) return 8'h80;
			return v[7:0];
		endfunction

		function void drop_pending(int p);
			acc_x[p] = 0;
			acc_y[p] = 0;
			wheel_acc[p] = 0;
			touched[p] = 1'b0;
		endfunction

		function void take_snapshot(int p, inout result_t r);
			r.update_flag = touched[p];
			r.button_state = buttons[p];
			r.x_motion = clip8(acc_x[p]);
			r.y_motion = clip8(acc_y[p]);
			r.wheel_motion = clip8(wheel_acc[p]);
			drop_pending(p);
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Work out the result of one accepted command beat and queue it.
		function void note_item(item_t it);
			result_t r;
			int p;
			int lim;
			r = '0;
			p = int'(it.port);
			lim = (ports_in_use > N_PORTS) ? N_PORTS : int'(ports_in_use);
			case (it.command)
				CMD_MOVE, CMD_BUTTON, CMD_WHEEL: begin
					if (ports_in_use == 0 || p >= N_PORTS) begin
						r.status = ST_IGNORED;
					end else begin
						connected[p] = 1'b1;
						if (it.command == CMD_MOVE) begin
							acc_x[p] = saturate16(acc_x[p] + $signed(it.delta_x));
							acc_y[p] = saturate16(acc_y[p] + $signed(it.delta_y));
						end else if (it.command == CMD_BUTTON) begin
							if (it.pressed) buttons[p] = buttons[p] | it.button_bits;
							else buttons[p] = buttons[p] & ~it.button_bits;
						end else begin
							wheel_acc[p] = saturate16(wheel_acc[p] + $signed(it.wheel_step));
						end
						touched[p] = 1'b1;
						r.status = ST_OK;
					end
				end
				CMD_READ, CMD_LIST: begin
					if (ports_in_use == 0) begin
						r.status = ST_UNINIT;
					end else if (p >= lim) begin
						r.status = ST_BAD_PORT;
					end else if (!connected[p]) begin
						r.status = ST_NO_DEVICE;
					end else begin
						r.status = ST_OK;
						if (it.command == CMD_READ) begin
							take_snapshot(p, r);
						end else if (touched[p]) begin
							r.entry_count = 1'b1;
							take_snapshot(p, r);
						end
					end
				end
				CMD_CLEAR: begin
					if (ports_in_use == 0) begin
						r.status = ST_UNINIT;
					end else if (p >= N_PORTS) begin
						r.status = ST_BAD_PORT;
					end else begin
						drop_pending(p);
						r.status = ST_OK;
					end
				end
				default: begin
					r.status = ST_IGNORED;
				end
			endcase
			owed_q.push_back(r);
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= MAX_REPORTS) $display("%s", msg);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (owed_q.size() == 0) begin
				note_failure($sformatf("result beat with nothing owed: status %0d", got.status));
				return;
			end
			want = owed_q.pop_front();
			if (got.status !== want.status || got.entry_count !== want.entry_count ||
					got.update_flag !== want.update_flag ||
					got.button_state !== want.button_state ||
					got.x_motion !== want.x_motion || got.y_motion !== want.y_motion ||
					got.wheel_motion !== want.wheel_motion) begin
				note_failure($sformatf(
					"mismatch exp st=%0d cnt=%0d upd=%0d btn=%h x=%0d y=%0d w=%0d | got st=%0d cnt=%0d upd=%0d btn=%h x=%0d y=%0d w=%0d",
					want.status, want.entry_count, want.update_flag, want.button_state,
					$signed(want.x_motion), $signed(want.y_motion), $signed(want.wheel_motion),
					got.status, got.entry_count, got.update_flag, got.button_state,
					$signed(got.x_motion), $signed(got.y_motion), $signed(got.wheel_motion)));
			end
		endfunction
	endclass

	mouse_scoreboard sb;

	// 10 ns clock, high then low.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: decide result_ready for the next edge at every falling edge.
	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Sample both channels at the rising edge; values here are the pre-edge ones.
	always @(posedge clk) begin : beat_monitor
		item_t   took;
		result_t came;
		if (arst_n && item_valid && item_ready) begin
			took = '{command, port, delta_x, delta_y, wheel_step, button_bits, pressed};
			sb.note_item(took);
		end
		if (arst_n && result_valid && result_ready) begin
			came = '{status, entry_count, update_flag, button_state,
				x_motion, y_motion, wheel_motion};
			sb.check_result(came);
		end
	end

	// Watchdog: end the run when no beat or register write moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Present one command beat and hold it until accepted. An idle gap, if drawn,
	// drops valid first; otherwise valid stays high straight into the new beat.
	task automatic push_beat(item_t it);
		int gap;
		gap = 0;
		while (send_idle_pct > 0 && gap < MAX_SEND_GAP &&
				$urandom_range(99) < send_idle_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		command <= it.command;
		port <= it.port;
		delta_x <= it.delta_x;
		delta_y <= it.delta_y;
		wheel_step <= it.wheel_step;
		button_bits <= it.button_bits;
		pressed <= it.pressed;
		do @(posedge clk); while (!item_ready);
	endtask

	// Drop valid and hold off until every owed result has come back, then let
	// the two-stage pipeline settle.
	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of ports_in_use: setup cycle, then access cycle until pready.
	task automatic write_ports_in_use(logic [3:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PIU_ADDR;
		pwdata <= {28'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_ports_in_use(v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic item_t beat_of(logic [2:0] cmd, logic [7:0] p, logic [7:0] dx,
			logic [7:0] dy, logic [7:0] ws, logic [7:0] bits, logic pr);
		item_t it;
		it.command = cmd;
		it.port = p;
		it.delta_x = dx;
		it.delta_y = dy;
		it.wheel_step = ws;
		it.button_bits = bits;
		it.pressed = pr;
		return it;
	endfunction

	// Mostly well-formed commands on readable ports; the rest is noise over the
	// whole port range and every command code, unknown ones included.
	function automatic item_t random_beat();
		item_t       it;
		int unsigned lim;
		int unsigned pick;
		it.command = 3'($urandom);
		it.port = 8'($urandom);
		it.delta_x = 8'($urandom);
		it.delta_y = 8'($urandom);
		it.wheel_step = 8'($urandom);
		it.button_bits = 8'($urandom);
		it.pressed = 1'($urandom);
		if ($urandom_range(99) < 85) begin
			lim = (sb.ports_in_use == 0 || sb.ports_in_use > N_PORTS) ?
				N_PORTS : 32'(sb.ports_in_use);
			it.port = ($urandom_range(4) != 0) ? 8'($urandom_range(lim - 1)) :
				8'($urandom_range(N_PORTS - 1));
			pick = $urandom_range(99);
			if (pick < 30) it.command = CMD_MOVE;
			else if (pick < 45) it.command = CMD_BUTTON;
			else if (pick < 60) it.command = CMD_WHEEL;
			else if (pick < 78) it.command = CMD_READ;
			else if (pick < 93) it.command = CMD_LIST;
			else it.command = CMD_CLEAR;
		end
		return it;
	endfunction

	// Drive one port's sums past the 16-bit limit with extreme deltas, then read.
	task automatic saturate_port(bit use_wheel, logic [7:0] p);
		item_t it;
		bit    up;
		up = 1'($urandom_range(1));
		it = beat_of(use_wheel ? CMD_WHEEL : CMD_MOVE, p,
			up ? 8'h7f : 8'h80, up ? 8'h80 : 8'h7f, up ? 8'h7f : 8'h80, 8'h00, 1'b0);
		repeat ($urandom_range(260, 290)) push_beat(it);
		it.command = CMD_READ;
		push_beat(it);
	endtask

	task automatic run_phase(logic [3:0] piu, int send_pct, int recv_pct, int beats,
			int burst);
		int lim;
		drain_results();
		write_ports_in_use(piu);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		lim = (piu == 0 || piu > N_PORTS) ? N_PORTS : int'(piu);
		if (burst == BURST_MOVE) saturate_port(1'b0, 8'($urandom_range(lim - 1)));
		else if (burst == BURST_WHEEL) saturate_port(1'b1, 8'($urandom_range(lim - 1)));
		for (int i = 0; i < beats; i++) begin
			// Pause mid-phase until the block has returned everything.
			if (i == beats / 2) drain_results();
			push_beat(random_beat());
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Uninitialized block: events ignored, requests refused.
		push_beat(beat_of(CMD_MOVE, 8'd0, 8'd5, 8'd5, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_LIST, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		drain_results();
		write_ports_in_use(4'd8);

		// Extreme deltas and button masks on port 0, read back clamped.
		push_beat(beat_of(CMD_MOVE, 8'd0, 8'h7f, 8'h80, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_MOVE, 8'd0, 8'h7f, 8'h80, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_WHEEL, 8'd0, 8'd0, 8'd0, 8'h80, 8'h00, 1'b0));
		push_beat(beat_of(CMD_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'hff, 1'b1));
		push_beat(beat_of(CMD_BUTTON, 8'd0, 8'd0, 8'd0, 8'd0, 8'h0f, 1'b0));
		push_beat(beat_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		// List read with nothing pending.
		push_beat(beat_of(CMD_LIST, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		// Unconnected ports, out-of-range ports.
		push_beat(beat_of(CMD_READ, 8'd3, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_LIST, 8'd7, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_READ, 8'd8, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_MOVE, 8'd8, 8'd1, 8'd1, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_BUTTON, 8'd255, 8'd0, 8'd0, 8'd0, 8'hff, 1'b1));
		push_beat(beat_of(CMD_CLEAR, 8'd255, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		// Clear on an unconnected port still succeeds; a wheel event connects it.
		push_beat(beat_of(CMD_CLEAR, 8'd5, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_WHEEL, 8'd5, 8'd0, 8'd0, 8'h7f, 8'h00, 1'b0));
		push_beat(beat_of(CMD_LIST, 8'd5, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		// Unknown command codes.
		push_beat(beat_of(CMD_RSVD_A, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_RSVD_B, 8'd1, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		// Clear drops pending motion and the update flag.
		push_beat(beat_of(CMD_MOVE, 8'd2, 8'hff, 8'h01, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_CLEAR, 8'd2, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));
		push_beat(beat_of(CMD_READ, 8'd2, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0));

		// Random phases: port count, sender idle %, receiver stall %, beats, burst.
		// Lowering the count keeps state; raising it wipes every port.
		run_phase(4'd8, 0, 0, 220, BURST_MOVE);
		run_phase(4'd3, 74, 0, 220, BURST_NONE);
		run_phase(4'd1, 0, 74, 220, BURST_NONE);
		run_phase(4'd0, 11, 11, 100, BURST_NONE);
		run_phase(4'd6, 74, 0, 250, BURST_WHEEL);
		run_phase(4'd8, 11, 11, 250, BURST_NONE);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
